FILE: design/csdm_pkg.sv
// Shared types and constants for the concentric square-to-disk mapping core.
// No dependencies; used by every module of the block.
`default_nettype none
package csdm_pkg;

  // Sample precision (bits of the unit-square coordinates)
  localparam int SAMPLE_BITS = 16;
  localparam int PORT_W      = 16;
  localparam int OUT_W       = 16;

  // Recentred magnitude and division remainder widths
  localparam int MAG_W = SAMPLE_BITS + 1;
  localparam int REM_W = SAMPLE_BITS + 1;

  // Quotient minor/major in Q1.30, 31 bits, one division cell per bit
  localparam int Q_BITS = 31;
  // Angle, its square and the polynomial terms are Q0.30 below one: 30 bits
  localparam int T_W = 30;
  // Horner coefficients reach exactly one: 31 bits
  localparam int K_W = 31;
  localparam logic [K_W-1:0] Q30_ONE = K_W'(1) << 30;

  // pi/4 in Q0.32
  localparam logic [31:0] PI4_Q32 = 32'hC90FDAA2;

  // Reciprocals floor(2^32/d) for the constant divisions of the series
  localparam int D_W = 6;
  localparam int R_W = 32;
  localparam logic [D_W-1:0] DIV_S1 = D_W'(42);
  localparam logic [D_W-1:0] DIV_S2 = D_W'(20);
  localparam logic [D_W-1:0] DIV_S3 = D_W'(6);
  localparam logic [D_W-1:0] DIV_C1 = D_W'(56);
  localparam logic [D_W-1:0] DIV_C2 = D_W'(30);
  localparam logic [D_W-1:0] DIV_C3 = D_W'(12);
  localparam logic [R_W-1:0] RCP_S1 = R_W'((64'd1 << 32) / 42);
  localparam logic [R_W-1:0] RCP_S2 = R_W'((64'd1 << 32) / 20);
  localparam logic [R_W-1:0] RCP_S3 = R_W'((64'd1 << 32) / 6);
  localparam logic [R_W-1:0] RCP_C1 = R_W'((64'd1 << 32) / 56);
  localparam logic [R_W-1:0] RCP_C2 = R_W'((64'd1 << 32) / 30);
  localparam logic [R_W-1:0] RCP_C3 = R_W'((64'd1 << 32) / 12);

  // Output scaling: magnitude = (r * comp + 2^(SB+14)) >> (SB+15)
  localparam int PROD_W = MAG_W + K_W;
  localparam logic [PROD_W:0] RND = (PROD_W + 1)'(1) << (SAMPLE_BITS + 14);
  localparam int SCL_SH = SAMPLE_BITS + 15;
  localparam int SMAG_W = PROD_W + 1 - SCL_SH;
  localparam logic [SMAG_W-1:0] POS_MAX = SMAG_W'(32767);
  localparam logic [SMAG_W-1:0] NEG_MAX = SMAG_W'(32768);

  typedef enum logic [1:0] {
    WEDGE_E = 2'd0,
    WEDGE_N = 2'd1,
    WEDGE_W = 2'd2,
    WEDGE_S = 2'd3
  } wedge_t;

  // Per-item data riding alongside the arithmetic
  typedef struct packed {
    logic [MAG_W-1:0] major;
    wedge_t           wedge;
    logic             sneg;
  } side_t;

  typedef struct packed {
    logic [T_W-1:0] t;
    logic [T_W-1:0] t2;
    side_t          side;
  } carry_t;

endpackage
`default_nettype wire

FILE: design/csdm_div_cell.sv
// One restoring-division cell: produces one quotient bit of minor/major.
// Depends on csdm_pkg.
`default_nettype none
module csdm_div_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         vin,
  input  wire logic [csdm_pkg::REM_W-1:0]   rem_in,
  input  wire logic [csdm_pkg::Q_BITS-1:0]  q_in,
  input  wire csdm_pkg::side_t              side_in,
  output logic                              vout,
  output logic [csdm_pkg::REM_W-1:0]        rem_out,
  output logic [csdm_pkg::Q_BITS-1:0]       q_out,
  output csdm_pkg::side_t                   side_out
);

  logic                       bit_q;
  logic [csdm_pkg::REM_W-1:0] rem_sub;
  logic [csdm_pkg::REM_W-1:0] divisor;

  // Trial subtract; remainder below major is doubled for the next bit
  always_comb begin
    divisor = csdm_pkg::REM_W'(side_in.major);
    bit_q   = (rem_in >= divisor);
    rem_sub = bit_q ? (rem_in - divisor) : rem_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= {rem_sub[csdm_pkg::REM_W-2:0], 1'b0};
      q_out    <= {q_in[csdm_pkg::Q_BITS-2:0], bit_q};
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

FILE: design/csdm_poly_cell.sv
// One Horner step of the sine and cosine series, three registered stages:
// reciprocal multiply, quotient correction, multiply by the angle term.
// Depends on csdm_pkg.
`default_nettype none
module csdm_poly_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        last,
  input  wire logic [csdm_pkg::D_W-1:0]    ds,
  input  wire logic [csdm_pkg::R_W-1:0]    rs,
  input  wire logic [csdm_pkg::D_W-1:0]    dc,
  input  wire logic [csdm_pkg::R_W-1:0]    rc,
  input  wire logic                        vin,
  input  wire logic [csdm_pkg::T_W-1:0]    ms_in,
  input  wire logic [csdm_pkg::T_W-1:0]    mc_in,
  input  wire csdm_pkg::carry_t            cin,
  output logic                             vout,
  output logic [csdm_pkg::T_W-1:0]         ms_out,
  output logic [csdm_pkg::T_W-1:0]         mc_out,
  output csdm_pkg::carry_t                 cout
);

  localparam int EST_W = csdm_pkg::T_W + csdm_pkg::R_W;

  logic                      va, vb;
  logic [csdm_pkg::T_W-1:0]  ms_a, mc_a;
  logic [csdm_pkg::T_W-1:0]  qs_a, qc_a;
  logic [csdm_pkg::K_W-1:0]  ks_b, kc_b;
  csdm_pkg::carry_t          ca, cb;

  logic [EST_W-1:0]          ps, pc;
  logic [csdm_pkg::K_W-1:0]  rems, remc, qs_fix, qc_fix;
  logic [csdm_pkg::T_W-1:0]  ops;
  logic [csdm_pkg::T_W+csdm_pkg::K_W-1:0] ys, yc;

  // Quotient estimate, at most one short of the true floor
  always_comb begin
    ps = EST_W'(ms_in) * EST_W'(rs);
    pc = EST_W'(mc_in) * EST_W'(rc);
  end

  // Correct the estimate and form one minus the quotient
  always_comb begin
    rems   = csdm_pkg::K_W'(ms_a) - csdm_pkg::K_W'(qs_a) * csdm_pkg::K_W'(ds);
    remc   = csdm_pkg::K_W'(mc_a) - csdm_pkg::K_W'(qc_a) * csdm_pkg::K_W'(dc);
    qs_fix = csdm_pkg::K_W'(qs_a) + ((rems >= csdm_pkg::K_W'(ds)) ? 31'd1 : 31'd0);
    qc_fix = csdm_pkg::K_W'(qc_a) + ((remc >= csdm_pkg::K_W'(dc)) ? 31'd1 : 31'd0);
  end

  // Multiply by t^2, or by t in the last sine step
  always_comb begin
    ops = last ? cb.t : cb.t2;
    ys  = (csdm_pkg::T_W + csdm_pkg::K_W)'(ops) * (csdm_pkg::T_W + csdm_pkg::K_W)'(ks_b);
    yc  = (csdm_pkg::T_W + csdm_pkg::K_W)'(cb.t2) * (csdm_pkg::T_W + csdm_pkg::K_W)'(kc_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      va   <= vin;
      vb   <= va;
      vout <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms_a   <= ms_in;
      mc_a   <= mc_in;
      qs_a   <= ps[EST_W-1:32];
      qc_a   <= pc[EST_W-1:32];
      ca     <= cin;
      ks_b   <= csdm_pkg::Q30_ONE - qs_fix;
      kc_b   <= csdm_pkg::Q30_ONE - qc_fix;
      cb     <= ca;
      ms_out <= ys[csdm_pkg::T_W+29:30];
      mc_out <= yc[csdm_pkg::T_W+29:30];
      cout   <= cb;
    end
  end

endmodule
`default_nettype wire

FILE: design/concentric_square_to_disk_map_core.sv
// Concentric square-to-disk mapping core: front end, division chain,
// angle multiplies, series chain and output scaling. Depends on csdm_pkg,
// csdm_div_cell and csdm_poly_cell.
// Throughput one item per cycle while the chain advances, set by the fully
// pipelined chain (31 division cells, one per quotient bit, and three series
// cells of three stages each).
// The whole chain holds while a result waits in the output register.
// Reset clears every valid bit; payload registers are not reset.
`default_nettype none
module concentric_square_to_disk_map_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [csdm_pkg::PORT_W-1:0]     square_x,
  input  wire logic [csdm_pkg::PORT_W-1:0]     square_y,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [csdm_pkg::OUT_W-1:0]    disk_x,
  output logic signed [csdm_pkg::OUT_W-1:0]    disk_y
);

  localparam int SB = csdm_pkg::SAMPLE_BITS;
  localparam int ND = csdm_pkg::Q_BITS;
  localparam int NP = 3;
  localparam int PW = csdm_pkg::PROD_W;

  logic en;

  // Front end
  logic [SB-1:0]          sx, sy;
  logic signed [SB+1:0]   a, b;
  logic signed [SB+2:0]   sum;
  logic [SB+1:0]          ua_w, ub_w;
  logic [SB:0]            ua, ub;
  csdm_pkg::side_t        side0;
  logic [SB:0]            minor0;
  logic                   v0;
  csdm_pkg::side_t        s0_side;
  logic [SB:0]            s0_minor;

  // Division chain
  logic                           dv   [0:ND];
  logic [csdm_pkg::REM_W-1:0]     drem [0:ND];
  logic [csdm_pkg::Q_BITS-1:0]    dq   [0:ND];
  csdm_pkg::side_t                dside[0:ND];

  // Angle stages
  logic                           vt, vt2;
  logic [csdm_pkg::Q_BITS-1:0]    qm;
  logic [62:0]                    tprod;
  logic [2*csdm_pkg::T_W-1:0]     t2prod;
  logic [csdm_pkg::T_W-1:0]       t_r;
  csdm_pkg::side_t                t_side;
  csdm_pkg::carry_t               c2;

  // Series chain
  logic                           pv  [0:NP];
  logic [csdm_pkg::T_W-1:0]       pms [0:NP];
  logic [csdm_pkg::T_W-1:0]       pmc [0:NP];
  csdm_pkg::carry_t               pc  [0:NP];
  logic [csdm_pkg::D_W-1:0]       dsv [0:NP-1];
  logic [csdm_pkg::R_W-1:0]       rsv [0:NP-1];
  logic [csdm_pkg::D_W-1:0]       dcv [0:NP-1];
  logic [csdm_pkg::R_W-1:0]       rcv [0:NP-1];

  // Output scaling
  logic [csdm_pkg::K_W-1:0]       cs, sn, cx, cy;
  logic                           nx, ny;
  logic                           ve;
  logic [PW-1:0]                  px, py;
  logic                           enx, eny;
  logic [PW:0]                    rx, ry;
  logic [csdm_pkg::SMAG_W-1:0]    mx, my;
  logic [csdm_pkg::OUT_W-1:0]     ox, oy;

  // Whole chain advances unless a result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Recentre, pick the wedge and the dominant coordinate
  always_comb begin
    sx   = SB'(square_x);
    sy   = SB'(square_y);
    a    = $signed({1'b0, sx, 1'b0}) - $signed((SB+2)'(1) << SB);
    b    = $signed({1'b0, sy, 1'b0}) - $signed((SB+2)'(1) << SB);
    sum  = $signed({a[SB+1], a}) + $signed({b[SB+1], b});
    ua_w = a[SB+1] ? (SB+2)'(-a) : (SB+2)'(a);
    ub_w = b[SB+1] ? (SB+2)'(-b) : (SB+2)'(b);
    ua   = ua_w[SB:0];
    ub   = ub_w[SB:0];
    if (sum > 0) begin
      if (a > b) begin
        side0 = '{major: ua, wedge: csdm_pkg::WEDGE_E, sneg: b < 0};
        minor0 = ub;
      end else begin
        side0 = '{major: ub, wedge: csdm_pkg::WEDGE_N, sneg: a < 0};
        minor0 = ua;
      end
    end else begin
      if (a < b) begin
        side0 = '{major: ua, wedge: csdm_pkg::WEDGE_W, sneg: b > 0};
        minor0 = ub;
      end else begin
        side0 = '{major: ub, wedge: csdm_pkg::WEDGE_S, sneg: a > 0};
        minor0 = ua;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side  <= side0;
      s0_minor <= minor0;
    end
  end

  // Division chain, one quotient bit per cell
  assign dv[0]    = v0;
  assign drem[0]  = csdm_pkg::REM_W'(s0_minor);
  assign dq[0]    = '0;
  assign dside[0] = s0_side;

  for (genvar i = 0; i < ND; i++) begin : g_div
    csdm_div_cell u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vin      (dv[i]),
      .rem_in   (drem[i]),
      .q_in     (dq[i]),
      .side_in  (dside[i]),
      .vout     (dv[i+1]),
      .rem_out  (drem[i+1]),
      .q_out    (dq[i+1]),
      .side_out (dside[i+1])
    );
  end

  // Angle t = q * pi/4, then t squared; the origin forces q to zero
  always_comb begin
    qm     = (dside[ND].major == '0) ? '0 : dq[ND];
    tprod  = 63'(qm) * 63'(csdm_pkg::PI4_Q32);
    t2prod = (2*csdm_pkg::T_W)'(t_r) * (2*csdm_pkg::T_W)'(t_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt  <= 1'b0;
      vt2 <= 1'b0;
    end else if (en) begin
      vt  <= dv[ND];
      vt2 <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= tprod[61:32];
      t_side  <= dside[ND];
      c2.t    <= t_r;
      c2.t2   <= t2prod[2*csdm_pkg::T_W-1:30];
      c2.side <= t_side;
    end
  end

  // Series chain: sine and cosine Horner steps side by side
  assign dsv[0] = csdm_pkg::DIV_S1;
  assign dsv[1] = csdm_pkg::DIV_S2;
  assign dsv[2] = csdm_pkg::DIV_S3;
  assign rsv[0] = csdm_pkg::RCP_S1;
  assign rsv[1] = csdm_pkg::RCP_S2;
  assign rsv[2] = csdm_pkg::RCP_S3;
  assign dcv[0] = csdm_pkg::DIV_C1;
  assign dcv[1] = csdm_pkg::DIV_C2;
  assign dcv[2] = csdm_pkg::DIV_C3;
  assign rcv[0] = csdm_pkg::RCP_C1;
  assign rcv[1] = csdm_pkg::RCP_C2;
  assign rcv[2] = csdm_pkg::RCP_C3;

  assign pv[0]  = vt2;
  assign pms[0] = c2.t2;
  assign pmc[0] = c2.t2;
  assign pc[0]  = c2;

  for (genvar j = 0; j < NP; j++) begin : g_poly
    csdm_poly_cell u_poly (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .last   (j == NP - 1),
      .ds     (dsv[j]),
      .rs     (rsv[j]),
      .dc     (dcv[j]),
      .rc     (rcv[j]),
      .vin    (pv[j]),
      .ms_in  (pms[j]),
      .mc_in  (pmc[j]),
      .cin    (pc[j]),
      .vout   (pv[j+1]),
      .ms_out (pms[j+1]),
      .mc_out (pmc[j+1]),
      .cout   (pc[j+1])
    );
  end

  // Route sine and cosine to the axes by wedge, scale by the radius
  always_comb begin
    sn = csdm_pkg::K_W'(pms[NP]);
    cs = csdm_pkg::Q30_ONE - csdm_pkg::K_W'(pmc[NP] >> 1);
    case (pc[NP].side.wedge)
      csdm_pkg::WEDGE_E: begin
        cx = cs; nx = 1'b0; cy = sn; ny = pc[NP].side.sneg;
      end
      csdm_pkg::WEDGE_N: begin
        cx = sn; nx = pc[NP].side.sneg; cy = cs; ny = 1'b0;
      end
      csdm_pkg::WEDGE_W: begin
        cx = cs; nx = 1'b1; cy = sn; ny = !pc[NP].side.sneg;
      end
      default: begin
        cx = sn; nx = !pc[NP].side.sneg; cy = cs; ny = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= pv[NP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= PW'(pc[NP].side.major) * PW'(cx);
      py  <= PW'(pc[NP].side.major) * PW'(cy);
      enx <= nx;
      eny <= ny;
    end
  end

  // Round half up, saturate, apply the sign
  always_comb begin
    rx = {1'b0, px} + csdm_pkg::RND;
    ry = {1'b0, py} + csdm_pkg::RND;
    mx = rx[PW:csdm_pkg::SCL_SH];
    my = ry[PW:csdm_pkg::SCL_SH];
    if (enx) begin
      ox = (mx > csdm_pkg::NEG_MAX) ? csdm_pkg::OUT_W'(-csdm_pkg::NEG_MAX)
                                    : csdm_pkg::OUT_W'(-mx);
    end else begin
      ox = (mx > csdm_pkg::POS_MAX) ? csdm_pkg::OUT_W'(csdm_pkg::POS_MAX)
                                    : csdm_pkg::OUT_W'(mx);
    end
    if (eny) begin
      oy = (my > csdm_pkg::NEG_MAX) ? csdm_pkg::OUT_W'(-csdm_pkg::NEG_MAX)
                                    : csdm_pkg::OUT_W'(-my);
    end else begin
      oy = (my > csdm_pkg::POS_MAX) ? csdm_pkg::OUT_W'(csdm_pkg::POS_MAX)
                                    : csdm_pkg::OUT_W'(my);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disk_x <= $signed(ox);
      disk_y <= $signed(oy);
    end
  end

endmodule
`default_nettype wire
